### sv/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Types and constants shared by the phone number duplicate counter.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 28;
    localparam int RPT_W       = 11;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [RPT_W-1:0] RPT_MAX   = {RPT_W{1'b1}};
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        FN_CHAR  = 2'd0,
        FN_END   = 2'd1,
        FN_DRAIN = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_BAD      = 3'd1,
        ST_FULL     = 3'd2,
        ST_DUP      = 3'd3,
        ST_NODUP    = 3'd4,
        ST_END      = 3'd5
    } t_status;

    // Insert may place a new key; update only bumps an existing count.
    typedef enum logic [1:0] {
        OP_INS = 2'd0,
        OP_UPD = 2'd1,
        OP_DRN = 2'd2
    } t_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic             vld;
        t_op              op;
        logic             alive;
        logic             hit;
        logic [KEY_W-1:0] key;
        logic [RPT_W-1:0] cnt;
        logic [CNT_W-1:0] pos;
    } t_tok;

    typedef struct packed {
        logic occupied;
        logic searchable;
    } t_cell_ctl;

endpackage

### sv/pdc_entry.sv
// ----------------------------------------------------------------------------
// pdc_entry
// Collects the characters of one entry into a seven digit BCD key.
// ----------------------------------------------------------------------------
module pdc_entry (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_char_vld,
    input  logic [7:0]                 i_char,
    input  logic                       i_flush,
    output logic [pdc_pkg::KEY_W-1:0]  o_key,
    output logic                       o_ok
);
    import pdc_pkg::*;

    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_NINE = 8'h39;
    localparam logic [7:0] CHR_UA   = 8'h41;
    localparam logic [7:0] CHR_UZ   = 8'h5A;
    localparam logic [7:0] CHR_LA   = 8'h61;
    localparam logic [7:0] CHR_LZ   = 8'h7A;
    localparam logic [3:0] NUM_DIGITS = 4'd7;
    localparam logic [3:0] TOO_MANY   = 4'd8;

    // Returns {has_digit, digit} for a letter offset from 'A'.
    function automatic logic [4:0] keypad(input logic [4:0] idx);
        logic [4:0] res;
        unique case (idx)
            5'd0, 5'd1, 5'd2:    res = {1'b1, 4'd2};
            5'd3, 5'd4, 5'd5:    res = {1'b1, 4'd3};
            5'd6, 5'd7, 5'd8:    res = {1'b1, 4'd4};
            5'd9, 5'd10, 5'd11:  res = {1'b1, 4'd5};
            5'd12, 5'd13, 5'd14: res = {1'b1, 4'd6};
            5'd15, 5'd17, 5'd18: res = {1'b1, 4'd7};
            5'd19, 5'd20, 5'd21: res = {1'b1, 4'd8};
            5'd22, 5'd23, 5'd24: res = {1'b1, 4'd9};
            default:             res = {1'b0, 4'd0};
        endcase
        return res;
    endfunction

    logic [KEY_W-1:0] r_buf, n_buf;
    logic [3:0]       r_total, n_total;
    logic             r_bad, n_bad;
    logic [7:0]       w_ofs;
    logic [7:0]       w_num;
    logic [4:0]       w_pad;
    logic             w_push;
    logic [3:0]       w_digit;

    assign w_ofs = i_char - CHR_UA;
    assign w_num = i_char - CHR_ZERO;
    assign w_pad = keypad(w_ofs[4:0]);

    always_comb begin
        n_buf   = r_buf;
        n_total = r_total;
        n_bad   = r_bad;
        w_push  = 1'b0;
        w_digit = w_num[3:0];
        if (i_flush) begin
            n_buf   = '0;
            n_total = '0;
            n_bad   = 1'b0;
        end else if (i_char_vld) begin
            if (i_char >= CHR_ZERO && i_char <= CHR_NINE) begin
                w_push = 1'b1;
            end else if (i_char >= CHR_UA && i_char <= CHR_UZ) begin
                w_digit = w_pad[3:0];
                if (w_pad[4]) begin
                    w_push = 1'b1;
                end else begin
                    n_bad = 1'b1;
                end
            end else if (i_char >= CHR_LA && i_char <= CHR_LZ) begin
                n_bad = 1'b1;
            end
            if (w_push) begin
                if (r_total < NUM_DIGITS) begin
                    n_buf   = {r_buf[KEY_W-5:0], w_digit};
                    n_total = r_total + 1'b1;
                end else begin
                    // Extra digits are dropped and the count sticks at eight.
                    n_total = TOO_MANY;
                    n_bad   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_total <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_total <= n_total;
            r_bad   <= n_bad;
        end
    end

    assign o_key = r_buf;
    assign o_ok  = !r_bad && (r_total == NUM_DIGITS);

endmodule

### sv/pdc_cell.sv
// ----------------------------------------------------------------------------
// pdc_cell
// One table slot: holds a key and its count and acts on the passing token.
// ----------------------------------------------------------------------------
module pdc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdc_pkg::t_cell_ctl    i_ctl,
    input  pdc_pkg::t_tok         i_tok,
    output pdc_pkg::t_tok         o_tok
);
    import pdc_pkg::*;

    logic [KEY_W-1:0] r_key, n_key;
    logic [RPT_W-1:0] r_cnt, n_cnt;
    t_tok             r_tok, n_tok;
    logic [RPT_W-1:0] w_cnt_inc;

    assign w_cnt_inc = (r_cnt == RPT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_key = r_key;
        n_cnt = r_cnt;
        n_tok = i_tok;
        if (i_tok.vld && i_tok.alive) begin
            n_tok.pos = i_tok.pos + 1'b1;
            unique case (i_tok.op)
                OP_INS: begin
                    if (!i_ctl.occupied) begin
                        n_key       = i_tok.key;
                        n_cnt       = i_tok.cnt;
                        n_tok.alive = 1'b0;
                    end else if (r_key == i_tok.key) begin
                        n_cnt       = w_cnt_inc;
                        n_tok.alive = 1'b0;
                        n_tok.hit   = 1'b1;
                    end else if (r_key > i_tok.key) begin
                        // Take the token's entry and push ours one slot up.
                        n_key     = i_tok.key;
                        n_cnt     = i_tok.cnt;
                        n_tok.key = r_key;
                        n_tok.cnt = r_cnt;
                    end
                end
                OP_UPD: begin
                    if (i_ctl.occupied && r_key == i_tok.key) begin
                        n_cnt       = w_cnt_inc;
                        n_tok.alive = 1'b0;
                        n_tok.hit   = 1'b1;
                    end
                end
                OP_DRN: begin
                    if (i_ctl.searchable && r_cnt > RPT_W'(1)) begin
                        n_tok.key   = r_key;
                        n_tok.cnt   = r_cnt;
                        n_tok.alive = 1'b0;
                        n_tok.hit   = 1'b1;
                    end
                end
                default: begin
                    n_tok.alive = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/pdc_chain.sv
// ----------------------------------------------------------------------------
// pdc_chain
// Row of table cells; the token moves one cell further every cycle.
// ----------------------------------------------------------------------------
module pdc_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pdc_pkg::CNT_W-1:0]   i_keys_used,
    input  logic [pdc_pkg::CNT_W-1:0]   i_drain_pos,
    input  pdc_pkg::t_tok               i_tok,
    output pdc_pkg::t_tok               o_tok
);
    import pdc_pkg::*;

    t_tok w_tok [TABLE_DEPTH+1];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;

        // Slots below the fill level hold sorted keys; the rest are free.
        assign w_ctl.occupied   = CNT_W'(g) < i_keys_used;
        assign w_ctl.searchable = w_ctl.occupied && (CNT_W'(g) >= i_drain_pos);

        pdc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[TABLE_DEPTH];

endmodule

### sv/phone_number_duplicate_counter.sv
// ----------------------------------------------------------------------------
// phone_number_duplicate_counter
// Character, clear and bad-entry transfers complete without a walk. End of entry
// with a valid key and drain send a token through the TABLE_DEPTH cell chain; the
// next input transfer is taken after the token leaves the chain and the result is
// registered. Synchronous active-low reset empties the table.
// ----------------------------------------------------------------------------
module phone_number_duplicate_counter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]   s_axis_tuser,   // [1:0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // [27:0] number_bcd, [38:28] repeat_count
    output logic [2:0]   m_axis_tuser    // [2:0] status
);
    import pdc_pkg::*;

    t_state           r_state, n_state;
    t_tok             r_launch, n_launch;
    logic [CNT_W-1:0] r_keys_used, n_keys_used;
    logic [CNT_W-1:0] r_drain_pos, n_drain_pos;
    logic             r_any_dup, n_any_dup;
    logic             r_out_vld, n_out_vld;
    t_status          r_out_status, n_out_status;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [RPT_W-1:0] r_out_cnt, n_out_cnt;

    logic             w_acc;
    t_func            w_func;
    logic             w_char_vld;
    logic             w_flush;
    logic [KEY_W-1:0] w_key;
    logic             w_key_ok;
    t_tok             w_exit;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_vld || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_func        = t_func'(s_axis_tuser);
    assign w_char_vld    = w_acc && (w_func == FN_CHAR);
    assign w_flush       = w_acc && (w_func == FN_END || w_func == FN_CLEAR);

    pdc_entry u_entry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char_vld (w_char_vld),
        .i_char     (s_axis_tdata),
        .i_flush    (w_flush),
        .o_key      (w_key),
        .o_ok       (w_key_ok)
    );

    pdc_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_keys_used (r_keys_used),
        .i_drain_pos (r_drain_pos),
        .i_tok       (r_launch),
        .o_tok       (w_exit)
    );

    always_comb begin
        n_state      = r_state;
        n_launch     = r_launch;
        n_launch.vld = 1'b0;
        n_keys_used  = r_keys_used;
        n_drain_pos  = r_drain_pos;
        n_any_dup    = r_any_dup;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_cnt    = r_out_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_func)
                        FN_CHAR: begin
                        end
                        FN_END: begin
                            if (w_key_ok) begin
                                n_launch.vld   = 1'b1;
                                n_launch.op    = (r_keys_used >= DEPTH_CNT) ? OP_UPD : OP_INS;
                                n_launch.alive = 1'b1;
                                n_launch.hit   = 1'b0;
                                n_launch.key   = w_key;
                                n_launch.cnt   = RPT_W'(1);
                                n_launch.pos   = '0;
                                n_state        = S_WALK;
                            end else begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_BAD;
                                n_out_key    = '0;
                                n_out_cnt    = '0;
                            end
                        end
                        FN_DRAIN: begin
                            n_launch.vld   = 1'b1;
                            n_launch.op    = OP_DRN;
                            n_launch.alive = 1'b1;
                            n_launch.hit   = 1'b0;
                            n_launch.key   = '0;
                            n_launch.cnt   = '0;
                            n_launch.pos   = '0;
                            n_state        = S_WALK;
                        end
                        FN_CLEAR: begin
                            n_keys_used = '0;
                            n_drain_pos = '0;
                            n_any_dup   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_exit.vld) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_out_key = '0;
                    n_out_cnt = '0;
                    unique case (w_exit.op)
                        OP_INS: begin
                            n_out_status = ST_ACCEPTED;
                            if (!w_exit.hit) begin
                                n_keys_used = r_keys_used + 1'b1;
                            end
                            n_drain_pos = '0;
                            n_any_dup   = 1'b0;
                        end
                        OP_UPD: begin
                            if (w_exit.hit) begin
                                n_out_status = ST_ACCEPTED;
                                n_drain_pos  = '0;
                                n_any_dup    = 1'b0;
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        OP_DRN: begin
                            if (w_exit.hit) begin
                                n_out_status = ST_DUP;
                                n_out_key    = w_exit.key;
                                n_out_cnt    = w_exit.cnt;
                                n_drain_pos  = w_exit.pos;
                                n_any_dup    = 1'b1;
                            end else begin
                                n_out_status = r_any_dup ? ST_END : ST_NODUP;
                                n_drain_pos  = '0;
                                n_any_dup    = 1'b0;
                            end
                        end
                        default: begin
                            n_out_status = ST_BAD;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_launch.op    <= n_launch.op;
        r_launch.alive <= n_launch.alive;
        r_launch.hit   <= n_launch.hit;
        r_launch.key   <= n_launch.key;
        r_launch.cnt   <= n_launch.cnt;
        r_launch.pos   <= n_launch.pos;
        r_out_status   <= n_out_status;
        r_out_key      <= n_out_key;
        r_out_cnt      <= n_out_cnt;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launch.vld <= 1'b0;
            r_keys_used  <= '0;
            r_drain_pos  <= '0;
            r_any_dup    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_launch.vld <= n_launch.vld;
            r_keys_used  <= n_keys_used;
            r_drain_pos  <= n_drain_pos;
            r_any_dup    <= n_any_dup;
            r_out_vld    <= n_out_vld;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_cnt, r_out_key};
    assign m_axis_tuser  = r_out_status;

    // A token can only leave the chain while a walk is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.vld |-> (r_state == S_WALK))
        else $error("token left the chain outside a walk");

    // Only one token is ever launched per accepted transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.vld |-> $past(w_acc))
        else $error("token launched without an input transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keys_used <= DEPTH_CNT)
        else $error("fill level above table depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_pos <= r_keys_used)
        else $error("drain position beyond filled slots");

    // With room left, an insert always finds a free slot before the end.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit.vld && w_exit.op == OP_INS) |-> !w_exit.alive)
        else $error("insert token fell off the chain");

endmodule
